// File: rtl/iiel_pkg.sv
package iiel_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 7;
	localparam int CNT_W    = 7;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [1:0] {
		OP_READ   = 2'd0,
		OP_INSERT = 2'd1,
		OP_ERASE  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Command broadcast to every cell of the chain in the cycle a transaction is accepted.
	typedef struct packed {
		logic                     ins;
		logic                     era;
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] val;
	} cell_cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_W-1:0]         count;
		status_t                  status;
	} result_t;

endpackage

// File: rtl/iiel_cell.sv
module iiel_cell (
	input  logic                              clk,
	input  logic [iiel_pkg::IDX_W-1:0]        idx,
	input  iiel_pkg::cell_cmd_t               cmd,
	input  logic signed [iiel_pkg::DATA_W-1:0] lower,
	input  logic signed [iiel_pkg::DATA_W-1:0] upper,
	output logic signed [iiel_pkg::DATA_W-1:0] entry,
	output logic signed [iiel_pkg::DATA_W-1:0] rd_value
);
	import iiel_pkg::*;

	logic [POS_W-1:0]         my_pos;
	logic                     hit;
	logic                     above;
	logic signed [DATA_W-1:0] entry_q;

	assign my_pos = POS_W'(idx);
	assign hit    = (my_pos == cmd.pos);
	assign above  = (my_pos > cmd.pos);

	// An insert pulls from the cell below; an erase pulls from the cell above.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (above) begin
				entry_q <= lower;
			end else if (hit) begin
				entry_q <= cmd.val;
			end
		end else if (cmd.era && (above || hit)) begin
			entry_q <= upper;
		end
	end

	assign entry    = entry_q;
	assign rd_value = hit ? entry_q : '0;

endmodule

// File: rtl/iiel_outbuf.sv
module iiel_outbuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  iiel_pkg::result_t    push_data,
	input  logic                 pop_stall,
	output logic                 valid,
	output logic                 full,
	output iiel_pkg::result_t    data
);
	import iiel_pkg::*;

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    take;

	assign take = main_valid_q && !pop_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (main_valid_q && !take) begin
					skid_valid_q <= 1'b1;
				end else begin
					main_valid_q <= 1'b1;
				end
			end else if (take) begin
				main_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !take) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

	assign valid = main_valid_q;
	assign full  = skid_valid_q;
	assign data  = main_q;

endmodule

// File: rtl/indexed_insert_erase_list.sv
// Ordered list of up to CAPACITY signed 32-bit values held in a chain of cells, one entry per
// cell. Each transaction reads, inserts or erases at a position and returns exactly one result
// with the value read, the element count afterwards and a status. All cells shift together, so
// one transaction is accepted per clock while in_stall is low; a two-entry output buffer lets the
// block keep taking requests while one result waits, and in_stall rises only when both buffer
// entries are occupied. Entries need no clearing after reset.
module indexed_insert_erase_list (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         op,
	input  logic [iiel_pkg::POS_W-1:0]         position,
	input  logic signed [iiel_pkg::DATA_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [iiel_pkg::DATA_W-1:0] read_value,
	output logic [iiel_pkg::CNT_W-1:0]         count,
	output logic [1:0]                         status
);
	import iiel_pkg::*;

	logic                     fire;
	logic                     buf_full;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         cnt_next;
	cell_cmd_t                cmd;
	result_t                  res;
	result_t                  out_data;
	logic signed [DATA_W-1:0] entry   [CAPACITY];
	logic signed [DATA_W-1:0] rd_cell [CAPACITY];
	logic signed [DATA_W-1:0] rd_any;

	assign in_stall = buf_full;
	assign fire     = in_valid && !buf_full;

	// Only the addressed cell presents a non-zero value, so an OR gathers the read.
	always_comb begin
		rd_any = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_any = rd_any | rd_cell[i];
		end
	end

	always_comb begin
		cmd.ins        = 1'b0;
		cmd.era        = 1'b0;
		cmd.pos        = position;
		cmd.val        = value;
		res.read_value = '0;
		res.status     = ST_OK;
		cnt_next       = cnt_q;
		unique case (op_t'(op))
			OP_READ: begin
				if (position < cnt_q) begin
					res.read_value = rd_any;
				end else begin
					res.status = ST_RANGE;
				end
			end
			OP_INSERT: begin
				if (cnt_q == CNT_W'(CAPACITY)) begin
					res.status = ST_FULL;
				end else if (position > cnt_q) begin
					res.status = ST_RANGE;
				end else begin
					cmd.ins  = fire;
					cnt_next = cnt_q + 1'b1;
				end
			end
			OP_ERASE: begin
				if (position < cnt_q) begin
					cmd.era  = fire;
					cnt_next = cnt_q - 1'b1;
				end else begin
					res.status = ST_RANGE;
				end
			end
			default: begin
				res.status = ST_RANGE;
			end
		endcase
		res.count = cnt_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (fire) begin
			cnt_q <= cnt_next;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] lower;
		logic signed [DATA_W-1:0] upper;

		if (i == 0) begin : g_first
			assign lower = value;
		end else begin : g_lower
			assign lower = entry[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper = '0;
		end else begin : g_upper
			assign upper = entry[i+1];
		end

		iiel_cell u_cell (
			.clk      (clk),
			.idx      (IDX_W'(i)),
			.cmd      (cmd),
			.lower    (lower),
			.upper    (upper),
			.entry    (entry[i]),
			.rd_value (rd_cell[i])
		);
	end

	iiel_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.push_data (res),
		.pop_stall (out_stall),
		.valid     (out_valid),
		.full      (buf_full),
		.data      (out_data)
	);

	assign read_value = out_data.read_value;
	assign count      = out_data.count;
	assign status     = out_data.status;

endmodule

// File: rtl/iiel_chk.sv
module iiel_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [iiel_pkg::DATA_W-1:0] read_value,
	input logic [iiel_pkg::CNT_W-1:0]         count,
	input logic [1:0]                         status
);
	import iiel_pkg::*;

	// The block only pushes back while a result is already on offer.
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("in_stall high with no result on offer");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count <= CNT_W'(CAPACITY)))
		else $error("count above capacity");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_FULL)) |-> (count == CNT_W'(CAPACITY)))
		else $error("full status reported below capacity");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK)) |-> (read_value == '0))
		else $error("refused transaction returned a non-zero value");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(read_value)
			&& $stable(count) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind indexed_insert_erase_list iiel_chk u_iiel_chk (.*);
